>>> hdl/csq_pkg.sv
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the cursor sequence store.
// ----------------------------------------------------------------------------
package csq_pkg;

	localparam int CAP_ENTRIES = 32;
	localparam int DATA_W      = 32;
	localparam int PTR_W       = $clog2(CAP_ENTRIES);
	localparam int CNT_W       = PTR_W + 1;

	localparam logic [3:0] OP_START     = 4'd0;
	localparam logic [3:0] OP_END       = 4'd1;
	localparam logic [3:0] OP_LAST      = 4'd2;
	localparam logic [3:0] OP_ADVANCE   = 4'd3;
	localparam logic [3:0] OP_RETREAT   = 4'd4;
	localparam logic [3:0] OP_INSERT    = 4'd5;
	localparam logic [3:0] OP_ATTACH    = 4'd6;
	localparam logic [3:0] OP_REMOVE    = 4'd7;
	localparam logic [3:0] OP_INS_FRONT = 4'd8;
	localparam logic [3:0] OP_ATT_BACK  = 4'd9;
	localparam logic [3:0] OP_RM_FRONT  = 4'd10;
	localparam logic [3:0] OP_READ_CUR  = 4'd11;
	localparam logic [3:0] OP_READ_IDX  = 4'd12;

	localparam logic [2:0] ERR_OK      = 3'd0;
	localparam logic [2:0] ERR_FULL    = 3'd1;
	localparam logic [2:0] ERR_NO_ITEM = 3'd2;
	localparam logic [2:0] ERR_EMPTY   = 3'd3;
	localparam logic [2:0] ERR_RANGE   = 3'd4;

	typedef struct packed {
		logic [3:0]        op;
		logic [DATA_W-1:0] value;
		logic [4:0]        index;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic [5:0]        entry_count;
		logic [4:0]        cursor_pos;
		logic              has_item;
		logic [2:0]        error_code;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_FILL,
		ST_READ,
		ST_CAPTURE
	} ctl_state_t;

	typedef enum logic [1:0] {
		PLAN_NONE,
		PLAN_INS,
		PLAN_RM,
		PLAN_READ
	} plan_t;

	typedef struct packed {
		logic load;
		logic plan;
		logic shift;
		logic fill;
		logic read;
		logic capture;
	} cmd_t;

	typedef struct packed {
		plan_t kind;
		logic  moves_zero;
		logic  shift_done;
		logic  ins_dir;
	} sts_t;

endpackage

>>> hdl/cursor_sequence_store.sv
// ----------------------------------------------------------------------------
// cursor_sequence_store
// Fixed-capacity ordered word store with a cursor.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_item  (op, value, index)
//   out      output     out_valid / out_ready  out_item (read_value .. error_code)
//
// Cursor moves and failed operations: decode state only, then result.
// Reads: decode, read and capture states (single read port, registered read data).
// Insert/attach: decode, shift if m > 0, then fill; remove: decode, then shift
// if m > 0; m = entries moved. The shift engine moves one entry per cycle through
// the memory port pair, then completes the last write before the done check.
// Reset clears count and cursor; entry memory is not cleared.
// A waiting result does not block acceptance once out_ready is high.
// ----------------------------------------------------------------------------
module cursor_sequence_store (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  csq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output csq_pkg::out_item_t out_item
);
	import csq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	csq_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	csq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

endmodule

>>> hdl/csq_datapath.sv
// ----------------------------------------------------------------------------
// csq_datapath
// Entry memory, count and cursor registers, operation decode, shift engine
// and result register.
// ----------------------------------------------------------------------------
module csq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  csq_pkg::in_item_t  in_item,
	input  csq_pkg::cmd_t      cmd,
	output csq_pkg::sts_t      sts,
	output csq_pkg::out_item_t out_item
);
	import csq_pkg::*;

	logic [DATA_W-1:0] mem [CAP_ENTRIES];

	logic [3:0]        op_q;
	logic [DATA_W-1:0] word_q;
	logic [PTR_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  cursor_q;
	logic [PTR_W-1:0]  pos_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  left_q;
	logic              dir_q;
	logic              pend_s1;
	logic [PTR_W-1:0]  waddr_s1;
	logic [DATA_W-1:0] rdata_q;
	out_item_t         res_q;

	logic              holds;
	logic              full;
	logic [2:0]        err;
	logic [CNT_W-1:0]  nxt_count;
	logic [PTR_W-1:0]  nxt_cursor;
	logic [PTR_W-1:0]  pos;
	plan_t             kind;
	logic [CNT_W-1:0]  moves;
	logic [CNT_W-1:0]  start_ptr;
	logic              shift_issue;
	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;

	assign holds = {1'b0, cursor_q} < count_q;
	assign full  = count_q >= CNT_W'(CAP_ENTRIES);

	always_comb begin
		err        = ERR_OK;
		nxt_count  = count_q;
		nxt_cursor = cursor_q;
		pos        = '0;
		kind       = PLAN_NONE;
		unique case (op_q) inside
			OP_START: nxt_cursor = '0;
			OP_END: nxt_cursor = (count_q != '0) ? PTR_W'(count_q - 1'b1) : '0;
			OP_LAST: nxt_cursor = PTR_W'(CAP_ENTRIES - 1);
			OP_ADVANCE: begin
				if (!holds)
					err = ERR_NO_ITEM;
				else if (cursor_q != PTR_W'(CAP_ENTRIES - 1))
					nxt_cursor = cursor_q + 1'b1;
			end
			OP_RETREAT: begin
				if (cursor_q != '0)
					nxt_cursor = cursor_q - 1'b1;
			end
			OP_INSERT, OP_ATTACH, OP_INS_FRONT, OP_ATT_BACK: begin
				if (full) begin
					err = ERR_FULL;
				end else begin
					kind      = PLAN_INS;
					nxt_count = count_q + 1'b1;
					if (op_q == OP_INSERT)
						pos = holds ? cursor_q : '0;
					else if (op_q == OP_ATTACH)
						pos = holds ? cursor_q + 1'b1 : PTR_W'(count_q);
					else if (op_q == OP_INS_FRONT)
						pos = '0;
					else
						pos = PTR_W'(count_q);
					nxt_cursor = pos;
				end
			end
			OP_REMOVE: begin
				if (!holds) begin
					err = ERR_NO_ITEM;
				end else begin
					kind       = PLAN_RM;
					pos        = cursor_q;
					nxt_count  = count_q - 1'b1;
					nxt_cursor = ({1'b0, cursor_q} < nxt_count) ? cursor_q : '0;
				end
			end
			OP_RM_FRONT: begin
				if (count_q == '0) begin
					err = ERR_EMPTY;
				end else begin
					kind       = PLAN_RM;
					pos        = '0;
					nxt_count  = count_q - 1'b1;
					nxt_cursor = '0;
				end
			end
			OP_READ_CUR: begin
				if (!holds) begin
					err = ERR_NO_ITEM;
				end else begin
					kind = PLAN_READ;
					pos  = cursor_q;
				end
			end
			OP_READ_IDX: begin
				if ({1'b0, idx_q} >= count_q) begin
					err = ERR_RANGE;
				end else begin
					kind = PLAN_READ;
					pos  = idx_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (kind == PLAN_INS) begin
			moves     = count_q - {1'b0, pos};
			start_ptr = count_q - 1'b1;
		end else begin
			moves     = count_q - 1'b1 - {1'b0, pos};
			start_ptr = {1'b0, pos} + 1'b1;
		end
	end

	assign shift_issue = cmd.shift && (left_q != '0);
	assign rd_en       = shift_issue || cmd.read;
	assign rd_addr     = cmd.read ? pos_q : rd_ptr_q;

	assign sts.kind       = kind;
	assign sts.moves_zero = (moves == '0);
	assign sts.shift_done = (left_q == '0) && !pend_s1;
	assign sts.ins_dir    = dir_q;

	assign out_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			left_q   <= '0;
			pend_s1  <= 1'b0;
		end else begin
			if (cmd.plan) begin
				count_q  <= nxt_count;
				cursor_q <= nxt_cursor;
				left_q   <= (kind == PLAN_INS || kind == PLAN_RM) ? moves : '0;
			end else if (shift_issue) begin
				left_q <= left_q - 1'b1;
			end
			pend_s1 <= shift_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_item.op;
			word_q <= in_item.value;
			idx_q  <= in_item.index;
		end
		if (cmd.plan) begin
			pos_q                <= pos;
			rd_ptr_q             <= PTR_W'(start_ptr);
			dir_q                <= (kind == PLAN_INS);
			res_q.read_value     <= '0;
			res_q.entry_count    <= nxt_count;
			res_q.cursor_pos     <= nxt_cursor;
			res_q.has_item       <= {1'b0, nxt_cursor} < nxt_count;
			res_q.error_code     <= err;
		end else if (shift_issue) begin
			rd_ptr_q <= dir_q ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
		end
		if (shift_issue)
			waddr_s1 <= dir_q ? rd_ptr_q + 1'b1 : rd_ptr_q - 1'b1;
		if (cmd.capture)
			res_q.read_value <= rdata_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[rd_addr];
		if (pend_s1)
			mem[waddr_s1] <= rdata_q;
		else if (cmd.fill)
			mem[pos_q] <= word_q;
	end

endmodule

>>> hdl/csq_controller.sv
// ----------------------------------------------------------------------------
// csq_controller
// Sequencer for one operation: decode, shift, fill, read and hand-off.
// ----------------------------------------------------------------------------
module csq_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  csq_pkg::sts_t  sts,
	output csq_pkg::cmd_t  cmd
);
	import csq_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (sts.kind)
					PLAN_INS:  state_nxt = sts.moves_zero ? ST_FILL : ST_SHIFT;
					PLAN_RM:   state_nxt = sts.moves_zero ? ST_IDLE : ST_SHIFT;
					PLAN_READ: state_nxt = ST_READ;
					default:   state_nxt = ST_IDLE;
				endcase
			end
			ST_SHIFT: begin
				if (sts.shift_done)
					state_nxt = sts.ins_dir ? ST_FILL : ST_IDLE;
			end
			ST_FILL:    state_nxt = ST_IDLE;
			ST_READ:    state_nxt = ST_CAPTURE;
			ST_CAPTURE: state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.plan    = (state_q == ST_EXEC);
		cmd.shift   = (state_q == ST_SHIFT);
		cmd.fill    = (state_q == ST_FILL);
		cmd.read    = (state_q == ST_READ);
		cmd.capture = (state_q == ST_CAPTURE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q != ST_IDLE && state_nxt == ST_IDLE)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cursor sequence store. A short table of
// directed operations, then phased random traffic that grows, drains and
// saturates the store. Every result is checked against a predictor of the
// store's contents, count and cursor. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import csq_pkg::*;

	localparam logic [3:0] OP_UNDEF_LO = 4'd13;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;

	localparam int DIR_ROWS        = 25;
	localparam int RANDOM_ITEMS    = 1500;
	localparam int CALM_TAIL       = 150;
	localparam int PHASE_ITEMS     = 60;
	localparam int HOLD_OFF_AT     = 600;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 80;
	localparam int MAX_PRINTS      = 40;

	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_ANY,
		MIX_TOP
	} mix_t;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_item   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_item;

	// predictor state
	logic [DATA_W-1:0] seq_words [CAP_ENTRIES];
	logic [5:0]        seq_count  = '0;
	logic [4:0]        seq_cursor = '0;

	out_item_t predicted_outcomes [$];
	out_item_t want_res;
	int        mismatch_count = 0;
	int        result_count   = 0;
	int        accepted_items = 0;
	int        quiet_cycles   = 0;
	int        send_gap_pct   = 0;
	bit        no_idle        = 1'b0;
	bit        hold_off_req   = 1'b0;
	bit        hold_off_done  = 1'b0;

	dir_row_t dir_rows [DIR_ROWS];

	cursor_sequence_store i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void open_slot(input int pos, input logic [DATA_W-1:0] word);
		int i;
		for (i = int'(seq_count); i > pos; i--)
			seq_words[i] = seq_words[i-1];
		seq_words[pos] = word;
		seq_count++;
	endfunction

	function automatic void close_slot(input int pos);
		int i;
		for (i = pos + 1; i < int'(seq_count); i++)
			seq_words[i-1] = seq_words[i];
		seq_count--;
	endfunction

	function automatic out_item_t step_sequence(input in_item_t it);
		out_item_t r;
		logic      full;
		logic      holds;
		r     = '0;
		full  = (seq_count >= CAP_ENTRIES);
		holds = ({1'b0, seq_cursor} < seq_count);
		r.error_code = ERR_OK;
		case (it.op)
			OP_START: seq_cursor = '0;
			OP_END: seq_cursor = (seq_count != 0) ? 5'(seq_count - 1) : '0;
			OP_LAST: seq_cursor = 5'(CAP_ENTRIES - 1);
			OP_ADVANCE: begin
				if (!holds)
					r.error_code = ERR_NO_ITEM;
				else if (seq_cursor != 5'(CAP_ENTRIES - 1))
					seq_cursor++;
			end
			OP_RETREAT: if (seq_cursor != 0) seq_cursor--;
			OP_INSERT: begin
				if (full) begin
					r.error_code = ERR_FULL;
				end else begin
					if (!holds)
						seq_cursor = '0;
					open_slot(int'(seq_cursor), it.value);
				end
			end
			OP_ATTACH: begin
				if (full) begin
					r.error_code = ERR_FULL;
				end else begin
					seq_cursor = holds ? seq_cursor + 5'd1 : 5'(seq_count);
					open_slot(int'(seq_cursor), it.value);
				end
			end
			OP_REMOVE: begin
				if (!holds) begin
					r.error_code = ERR_NO_ITEM;
				end else begin
					close_slot(int'(seq_cursor));
					if ({1'b0, seq_cursor} >= seq_count)
						seq_cursor = '0;
				end
			end
			OP_INS_FRONT: begin
				if (full) begin
					r.error_code = ERR_FULL;
				end else begin
					open_slot(0, it.value);
					seq_cursor = '0;
				end
			end
			OP_ATT_BACK: begin
				if (full) begin
					r.error_code = ERR_FULL;
				end else begin
					seq_cursor = 5'(seq_count);
					open_slot(int'(seq_cursor), it.value);
				end
			end
			OP_RM_FRONT: begin
				if (seq_count == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					close_slot(0);
					seq_cursor = '0;
				end
			end
			OP_READ_CUR: begin
				if (!holds)
					r.error_code = ERR_NO_ITEM;
				else
					r.read_value = seq_words[seq_cursor];
			end
			OP_READ_IDX: begin
				if ({1'b0, it.index} >= seq_count)
					r.error_code = ERR_RANGE;
				else
					r.read_value = seq_words[it.index];
			end
			default: ;
		endcase
		r.entry_count = seq_count;
		r.cursor_pos  = seq_cursor;
		r.has_item    = ({1'b0, seq_cursor} < seq_count);
		return r;
	endfunction

	function automatic in_item_t make_op(input mix_t mix);
		in_item_t it;
		int       roll;
		int       wr_to;
		int       rm_to;
		int       mv_to;
		int       rd_to;
		case (mix)
			MIX_GROW:   begin wr_to = 60; rm_to = 65; mv_to = 80; rd_to = 98; end
			MIX_SHRINK: begin wr_to = 12; rm_to = 52; mv_to = 72; rd_to = 98; end
			MIX_TOP:    begin wr_to = 25; rm_to = 32; mv_to = 70; rd_to = 98; end
			default:    begin wr_to = 30; rm_to = 48; mv_to = 72; rd_to = 98; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < wr_to) begin
			case ($urandom_range(0, 3))
				0:       it.op = OP_INSERT;
				1:       it.op = OP_ATTACH;
				2:       it.op = OP_INS_FRONT;
				default: it.op = OP_ATT_BACK;
			endcase
		end else if (roll < rm_to) begin
			it.op = $urandom_range(0, 1) ? OP_REMOVE : OP_RM_FRONT;
		end else if (roll < mv_to) begin
			if (mix == MIX_TOP && $urandom_range(0, 9) < 7) begin
				it.op = $urandom_range(0, 1) ? OP_LAST : OP_ADVANCE;
			end else begin
				case ($urandom_range(0, 4))
					0:       it.op = OP_START;
					1:       it.op = OP_END;
					2:       it.op = OP_LAST;
					3:       it.op = OP_ADVANCE;
					default: it.op = OP_RETREAT;
				endcase
			end
		end else if (roll < rd_to) begin
			it.op = $urandom_range(0, 1) ? OP_READ_CUR : OP_READ_IDX;
		end else begin
			it.op = OP_UNDEF_LO + 4'($urandom_range(0, 2));
		end
		case ($urandom_range(0, 7))
			0:       it.value = '0;
			1:       it.value = '1;
			default: it.value = $urandom;
		endcase
		if ($urandom_range(0, 1) && seq_count != 0)
			it.index = 5'($urandom_range(0, int'(seq_count) - 1));
		else
			it.index = 5'($urandom_range(0, 31));
		return it;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
	                             input logic [63:0] want);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t: result %0d %s: got %0h, want %0h",
			         $realtime, result_count, what, got, want);
		mismatch_count++;
	endtask

	// one operation: optional gap, offer, wait for accept, predict
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t pred;
		if (!no_idle && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = step_sequence(it);
		predicted_outcomes.push_back(typed ? want : pred);
		accepted_items++;
		if (accepted_items == HOLD_OFF_AT)
			hold_off_req = 1'b1;
		@(negedge clk);
	endtask

	initial begin
		mix_t mix;
		int   n;
		dir_rows = '{
			'{{OP_READ_CUR,  32'h0,         5'd0},  1'b1,
			  {32'h0, 6'd0, 5'd0, 1'b0, ERR_NO_ITEM}},
			'{{OP_RM_FRONT,  32'h0,         5'd0},  1'b1,
			  {32'h0, 6'd0, 5'd0, 1'b0, ERR_EMPTY}},
			'{{OP_REMOVE,    32'h0,         5'd0},  1'b1,
			  {32'h0, 6'd0, 5'd0, 1'b0, ERR_NO_ITEM}},
			'{{OP_ADVANCE,   32'h0,         5'd0},  1'b1,
			  {32'h0, 6'd0, 5'd0, 1'b0, ERR_NO_ITEM}},
			'{{OP_RETREAT,   32'h0,         5'd0},  1'b1,
			  {32'h0, 6'd0, 5'd0, 1'b0, ERR_OK}},
			'{{OP_END,       32'h0,         5'd0},  1'b1,
			  {32'h0, 6'd0, 5'd0, 1'b0, ERR_OK}},
			'{{OP_READ_IDX,  32'h0,         5'd31}, 1'b1,
			  {32'h0, 6'd0, 5'd0, 1'b0, ERR_RANGE}},
			'{{OP_LAST,      32'h0,         5'd0},  1'b1,
			  {32'h0, 6'd0, 5'd31, 1'b0, ERR_OK}},
			'{{OP_INSERT,    32'hFFFF_FFFF, 5'd0},  1'b1,
			  {32'h0, 6'd1, 5'd0, 1'b1, ERR_OK}},
			'{{OP_READ_CUR,  32'h0,         5'd0},  1'b1,
			  {32'hFFFF_FFFF, 6'd1, 5'd0, 1'b1, ERR_OK}},
			'{{OP_ATTACH,    32'h0,         5'd0},  1'b0, '0},
			'{{OP_INS_FRONT, 32'h8000_0001, 5'd0},  1'b0, '0},
			'{{OP_ATT_BACK,  32'h7FFF_FFFE, 5'd0},  1'b0, '0},
			'{{OP_READ_IDX,  32'h0,         5'd3},  1'b0, '0},
			'{{OP_READ_IDX,  32'h0,         5'd4},  1'b0, '0},
			'{{OP_START,     32'h0,         5'd0},  1'b0, '0},
			'{{OP_ADVANCE,   32'h0,         5'd0},  1'b0, '0},
			'{{OP_INSERT,    32'h1234_5678, 5'd0},  1'b0, '0},
			'{{OP_RETREAT,   32'h0,         5'd0},  1'b0, '0},
			'{{OP_END,       32'h0,         5'd0},  1'b0, '0},
			'{{OP_REMOVE,    32'h0,         5'd0},  1'b0, '0},
			'{{OP_LAST,      32'h0,         5'd0},  1'b0, '0},
			'{{OP_ATTACH,    32'hDEAD_BEEF, 5'd0},  1'b0, '0},
			'{{OP_UNDEF_LO,  32'h0,         5'd0},  1'b0, '0},
			'{{OP_UNDEF_HI,  32'hFFFF_FFFF, 5'd31}, 1'b0, '0}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (n = 0; n < DIR_ROWS; n++)
			send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);

		mix = MIX_ANY;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0) begin
				mix = mix_t'($urandom_range(0, 3));
				case ($urandom_range(0, 2))
					0:       send_gap_pct = 0;
					1:       send_gap_pct = 10;
					default: send_gap_pct = 35;
				endcase
			end
			if (n >= RANDOM_ITEMS - CALM_TAIL)
				no_idle = 1'b1;
			send_item(make_op(mix), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stalls plus one long hold-off to back the store up
	initial begin
		int stall_pct;
		int ticks;
		stall_pct = 0;
		ticks     = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
				out_ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
			ticks++;
			if (ticks % 150 == 0) begin
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (predicted_outcomes.size() == 0) begin
				note_mismatch("unexpected item", 64'(out_item), 64'h0);
			end else begin
				want_res = predicted_outcomes.pop_front();
				if (out_item.read_value !== want_res.read_value)
					note_mismatch("read_value", 64'(out_item.read_value),
					              64'(want_res.read_value));
				if (out_item.entry_count !== want_res.entry_count)
					note_mismatch("entry_count", 64'(out_item.entry_count),
					              64'(want_res.entry_count));
				if (out_item.cursor_pos !== want_res.cursor_pos)
					note_mismatch("cursor_pos", 64'(out_item.cursor_pos),
					              64'(want_res.cursor_pos));
				if (out_item.has_item !== want_res.has_item)
					note_mismatch("has_item", 64'(out_item.has_item),
					              64'(want_res.has_item));
				if (out_item.error_code !== want_res.error_code)
					note_mismatch("error_code", 64'(out_item.error_code),
					              64'(want_res.error_code));
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
